@@ hw/rtl/cfod_pkg.sv @@
// Shared types, codes and the multiply schedule of the field-of-view test.
package cfod_pkg;

    localparam int OPW       = 34;   // multiplier operand width
    localparam int SUMW      = 67;   // exact Q32.32 sum of three products
    localparam int DENW      = 47;   // pos_z << 16 for positive pos_z
    localparam int LIMW      = 60;   // image size times divisor
    localparam int QBITS     = 10;   // quotient bits kept by the divider
    localparam int NUM_TERMS = 18;
    localparam int NUM_SUMS  = 7;

    localparam logic signed [33:0]   Q_HALF     = 34'sd32768;
    localparam logic signed [33:0]   Q_TEN      = 34'sd655360;
    localparam logic signed [SUMW-1:0] NORM_LIMIT = 67'sd2147483648;

    localparam logic [2:0] SUM_NORM = 3'd0;
    localparam logic [2:0] SUM_PX   = 3'd1;
    localparam logic [2:0] SUM_PY   = 3'd2;
    localparam logic [2:0] SUM_LX   = 3'd3;
    localparam logic [2:0] SUM_LY   = 3'd4;
    localparam logic [2:0] SUM_UX   = 3'd5;
    localparam logic [2:0] SUM_UY   = 3'd6;

    typedef enum logic [1:0] {
        REQ_DEPTH = 2'd0,
        REQ_EMPTY = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        FOV_FREE     = 3'd0,
        FOV_BEHIND   = 3'd1,
        FOV_HORIZON  = 3'd2,
        FOV_OUTSIDE  = 3'd3,
        FOV_OCCLUDED = 3'd4
    } fov_t;

    typedef enum logic [2:0] {
        REG_FOCAL_X = 3'd0,
        REG_FOCAL_Y = 3'd1,
        REG_SKEW    = 3'd2,
        REG_CENTER_X = 3'd3,
        REG_CENTER_Y = 3'd4,
        REG_COLS    = 3'd5,
        REG_ROWS    = 3'd6
    } reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_CHECK,
        ST_DIVX,
        ST_DIVY,
        ST_READ,
        ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        A_X, A_Y, A_Z, A_FX, A_SK, A_CX, A_FY, A_CY
    } a_sel_t;

    typedef enum logic [2:0] {
        B_X, B_Y, B_Z, B_XM, B_XP, B_YP, B_YM
    } b_sel_t;

    typedef struct packed {
        a_sel_t     a;
        b_sel_t     b;
        logic       last;
        logic [2:0] idx;
    } term_t;

    typedef struct packed {
        logic       valid;
        logic       last;
        logic [2:0] idx;
    } mac_ctl_t;

    // Product schedule: norm, then the point and the two box corners.
    function automatic term_t term_at(input logic [4:0] k);
        term_t t;
        t = '{a: A_X, b: B_X, last: 1'b0, idx: SUM_NORM};
        unique case (k)
            5'd0:  t = '{a: A_X,  b: B_X,  last: 1'b0, idx: SUM_NORM};
            5'd1:  t = '{a: A_Y,  b: B_Y,  last: 1'b0, idx: SUM_NORM};
            5'd2:  t = '{a: A_Z,  b: B_Z,  last: 1'b1, idx: SUM_NORM};
            5'd3:  t = '{a: A_FX, b: B_X,  last: 1'b0, idx: SUM_PX};
            5'd4:  t = '{a: A_SK, b: B_Y,  last: 1'b0, idx: SUM_PX};
            5'd5:  t = '{a: A_CX, b: B_Z,  last: 1'b1, idx: SUM_PX};
            5'd6:  t = '{a: A_FY, b: B_Y,  last: 1'b0, idx: SUM_PY};
            5'd7:  t = '{a: A_CY, b: B_Z,  last: 1'b1, idx: SUM_PY};
            5'd8:  t = '{a: A_FX, b: B_XM, last: 1'b0, idx: SUM_LX};
            5'd9:  t = '{a: A_SK, b: B_YP, last: 1'b0, idx: SUM_LX};
            5'd10: t = '{a: A_CX, b: B_Z,  last: 1'b1, idx: SUM_LX};
            5'd11: t = '{a: A_FY, b: B_YP, last: 1'b0, idx: SUM_LY};
            5'd12: t = '{a: A_CY, b: B_Z,  last: 1'b1, idx: SUM_LY};
            5'd13: t = '{a: A_FX, b: B_XP, last: 1'b0, idx: SUM_UX};
            5'd14: t = '{a: A_SK, b: B_YM, last: 1'b0, idx: SUM_UX};
            5'd15: t = '{a: A_CX, b: B_Z,  last: 1'b1, idx: SUM_UX};
            5'd16: t = '{a: A_FY, b: B_YM, last: 1'b0, idx: SUM_UY};
            5'd17: t = '{a: A_CY, b: B_Z,  last: 1'b1, idx: SUM_UY};
            default: t = '{a: A_X, b: B_X, last: 1'b0, idx: SUM_NORM};
        endcase
        return t;
    endfunction

endpackage

@@ hw/rtl/cfod_mac.sv @@
// Shared multiplier with accumulator and the file of finished sums.
module cfod_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cfod_pkg::mac_ctl_t                ctl,
    input  logic signed [cfod_pkg::OPW-1:0]   op_a,
    input  logic signed [cfod_pkg::OPW-1:0]   op_b,
    output logic signed [cfod_pkg::SUMW-1:0]  sums [cfod_pkg::NUM_SUMS]
);

    logic signed [2*cfod_pkg::OPW-1:0] prod_reg;
    cfod_pkg::mac_ctl_t                pend_reg;
    logic signed [cfod_pkg::SUMW-1:0]  acc_reg;
    logic signed [cfod_pkg::SUMW-1:0]  acc_next;
    logic signed [cfod_pkg::SUMW-1:0]  sum_reg [cfod_pkg::NUM_SUMS];

    assign acc_next = acc_reg + $signed(prod_reg[cfod_pkg::SUMW-1:0]);

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        if (pend_reg.valid && pend_reg.last)
        begin
            sum_reg[pend_reg.idx] <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            pend_reg <= ctl;
            if (pend_reg.valid)
            begin
                // restart the sum after its last product
                acc_reg <= pend_reg.last ? '0 : acc_next;
            end
        end
    end

    assign sums = sum_reg;

endmodule

@@ hw/rtl/cfod_div.sv @@
// Restoring divider giving the low quotient bits of a pixel index.
module cfod_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [cfod_pkg::SUMW-1:0]   num,
    input  logic        [cfod_pkg::DENW-1:0]   den,
    output logic                               done,
    output logic        [cfod_pkg::QBITS-1:0]  quot
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [3:0]                        step_reg;
    logic signed [cfod_pkg::SUMW-1:0]  rem_reg;
    logic [cfod_pkg::QBITS-1:0]        q_reg;
    logic [cfod_pkg::SUMW-1:0]         shifted;
    logic signed [cfod_pkg::SUMW-1:0]  trial;

    assign shifted = {{(cfod_pkg::SUMW - cfod_pkg::DENW){1'b0}}, den} << step_reg;
    assign trial   = rem_reg - $signed(shifted);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 4'(cfod_pkg::QBITS - 1);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    step_reg <= step_reg - 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            // keep the remainder when the trial goes negative
            if (!trial[cfod_pkg::SUMW-1])
            begin
                rem_reg <= trial;
            end
            q_reg <= {q_reg[cfod_pkg::QBITS-2:0], ~trial[cfod_pkg::SUMW-1]};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

@@ hw/rtl/cfod_depth_mem.sv @@
// Depth image store: one write port, one registered read port.
module cfod_depth_mem #(
    parameter int AW = 18
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [32:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [32:0]   rdata
);

    logic [32:0] mem [2**AW];
    logic [32:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/camera_fov_occlusion_test.sv @@
// Top level: query sequencer, configuration registers and depth image.
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_stall   req_type .. depth_value
//  out      source     out_valid / out_stall fov_status
//  cfg      APB slave  psel/penable/pready   paddr, pwdata, prdata
//
// After acceptance a query runs 18 products through one shared 34x34 multiplier,
// then 7 bound checks and two 10-step restoring divisions, then one depth read.
// A waiting result in the output register holds the query in its last step,
// and the input stays stalled until the result leaves. Reset clears control
// and sets the configuration to zero with 512 columns and 512 rows;
// the depth image is not cleared.
module camera_fov_occlusion_test #(
    parameter int MAX_COLS = 512,
    parameter int MAX_ROWS = 512
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] box_x,
    input  logic signed [31:0] box_y,
    input  logic signed [31:0] box_z,
    input  logic               skip_horizon,
    input  logic               has_depth_map,
    input  logic [8:0]         pixel_col,
    input  logic [8:0]         pixel_row,
    input  logic signed [31:0] depth_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         fov_status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int AW = CW + RW;

    // configuration
    logic [30:0]        focal_x_reg;
    logic [30:0]        focal_y_reg;
    logic signed [31:0] skew_reg;
    logic signed [31:0] center_x_reg;
    logic signed [31:0] center_y_reg;
    logic [9:0]         cols_reg;
    logic [9:0]         rows_reg;

    cfod_pkg::state_t state_reg;
    cfod_pkg::state_t state_next;
    logic [4:0]       cnt_reg;

    // query operands and flags
    logic signed [31:0]             x_reg, y_reg, z_reg;
    logic signed [33:0]             xm_reg, xp_reg, yp_reg, ym_reg;
    logic [cfod_pkg::DENW-1:0]      den_reg;
    logic [cfod_pkg::LIMW-1:0]      limx_reg, limy_reg;
    logic                           colz_reg, rowz_reg;
    logic                           behind_reg, horizon_reg, nonpos_reg;
    logic                           ign_reg, have_reg, dead_reg, outside_reg;
    logic [cfod_pkg::QBITS-1:0]     px_reg, py_reg;
    logic                           out_valid_reg;
    logic [2:0]                     fov_status_reg;

    logic        in_acc, q_acc, fin_go;
    logic [32:0] bx_mag, by_mag, bz_mag;
    logic signed [33:0] xs, ys, zs;
    logic [12:0] cols_eff, rows_eff;

    cfod_pkg::mac_ctl_t                mac_ctl;
    cfod_pkg::term_t                   term;
    logic signed [cfod_pkg::OPW-1:0]   op_a, op_b;
    logic signed [cfod_pkg::SUMW-1:0]  sums [cfod_pkg::NUM_SUMS];
    logic signed [cfod_pkg::SUMW-1:0]  chk_n;
    logic                              chk_neg, bigx, bigy;

    logic                              div_start, div_done;
    logic signed [cfod_pkg::SUMW-1:0]  div_num;
    logic [cfod_pkg::QBITS-1:0]        div_q;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [32:0]   mem_wdata, mem_rdata;
    logic [12:0]   wcol_ext, wrow_ext, pcol_ext, prow_ext;
    logic [2:0]    fov_next;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= '0;
            focal_y_reg  <= '0;
            skew_reg     <= '0;
            center_x_reg <= '0;
            center_y_reg <= '0;
            cols_reg     <= 10'd512;
            rows_reg     <= 10'd512;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[4:2])
                cfod_pkg::REG_FOCAL_X:  focal_x_reg  <= pwdata[30:0];
                cfod_pkg::REG_FOCAL_Y:  focal_y_reg  <= pwdata[30:0];
                cfod_pkg::REG_SKEW:     skew_reg     <= pwdata;
                cfod_pkg::REG_CENTER_X: center_x_reg <= pwdata;
                cfod_pkg::REG_CENTER_Y: center_y_reg <= pwdata;
                cfod_pkg::REG_COLS:     cols_reg     <= pwdata[9:0];
                cfod_pkg::REG_ROWS:     rows_reg     <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            cfod_pkg::REG_FOCAL_X:  prdata = {1'b0, focal_x_reg};
            cfod_pkg::REG_FOCAL_Y:  prdata = {1'b0, focal_y_reg};
            cfod_pkg::REG_SKEW:     prdata = skew_reg;
            cfod_pkg::REG_CENTER_X: prdata = center_x_reg;
            cfod_pkg::REG_CENTER_Y: prdata = center_y_reg;
            cfod_pkg::REG_COLS:     prdata = {22'd0, cols_reg};
            cfod_pkg::REG_ROWS:     prdata = {22'd0, rows_reg};
            default:                prdata = '0;
        endcase
    end

    // ---------------- request intake ----------------
    assign in_stall = (state_reg != cfod_pkg::ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign q_acc    = in_acc && (req_type == cfod_pkg::REQ_QUERY);

    assign bx_mag = box_x[31] ? (33'd0 - {1'b1, box_x}) : {1'b0, box_x};
    assign by_mag = box_y[31] ? (33'd0 - {1'b1, box_y}) : {1'b0, box_y};
    assign bz_mag = box_z[31] ? (33'd0 - {1'b1, box_z}) : {1'b0, box_z};
    assign xs = {{2{pos_x[31]}}, pos_x};
    assign ys = {{2{pos_y[31]}}, pos_y};
    assign zs = {{2{pos_z[31]}}, pos_z};

    // clamp image size to the store
    assign cols_eff = ({3'd0, cols_reg} > 13'(MAX_COLS)) ? 13'(MAX_COLS) : {3'd0, cols_reg};
    assign rows_eff = ({3'd0, rows_reg} > 13'(MAX_ROWS)) ? 13'(MAX_ROWS) : {3'd0, rows_reg};

    always_ff @(posedge clk)
    begin
        if (q_acc)
        begin
            x_reg       <= pos_x;
            y_reg       <= pos_y;
            z_reg       <= pos_z;
            xm_reg      <= xs - $signed({1'b0, bx_mag});
            xp_reg      <= xs + $signed({1'b0, bx_mag});
            yp_reg      <= ys + $signed({1'b0, by_mag});
            ym_reg      <= ys - $signed({1'b0, by_mag});
            den_reg     <= {pos_z[30:0], 16'd0};
            limx_reg    <= cfod_pkg::LIMW'(cols_eff) * cfod_pkg::LIMW'({pos_z[30:0], 16'd0});
            limy_reg    <= cfod_pkg::LIMW'(rows_eff) * cfod_pkg::LIMW'({pos_z[30:0], 16'd0});
            colz_reg    <= (cols_eff == '0);
            rowz_reg    <= (rows_eff == '0);
            behind_reg  <= (zs - $signed({1'b0, bz_mag})) < -cfod_pkg::Q_HALF;
            horizon_reg <= !skip_horizon && ((zs + $signed({1'b0, bz_mag})) > cfod_pkg::Q_TEN);
            nonpos_reg  <= (pos_z <= 32'sd0);
            ign_reg     <= skip_horizon;
            have_reg    <= has_depth_map;
        end
    end

    // ---------------- products ----------------
    assign term = cfod_pkg::term_at(cnt_reg);

    always_comb
    begin
        unique case (term.a)
            cfod_pkg::A_X:  op_a = {{2{x_reg[31]}}, x_reg};
            cfod_pkg::A_Y:  op_a = {{2{y_reg[31]}}, y_reg};
            cfod_pkg::A_Z:  op_a = {{2{z_reg[31]}}, z_reg};
            cfod_pkg::A_FX: op_a = {3'd0, focal_x_reg};
            cfod_pkg::A_SK: op_a = {{2{skew_reg[31]}}, skew_reg};
            cfod_pkg::A_CX: op_a = {{2{center_x_reg[31]}}, center_x_reg};
            cfod_pkg::A_FY: op_a = {3'd0, focal_y_reg};
            cfod_pkg::A_CY: op_a = {{2{center_y_reg[31]}}, center_y_reg};
            default:        op_a = '0;
        endcase
        unique case (term.b)
            cfod_pkg::B_X:  op_b = {{2{x_reg[31]}}, x_reg};
            cfod_pkg::B_Y:  op_b = {{2{y_reg[31]}}, y_reg};
            cfod_pkg::B_Z:  op_b = {{2{z_reg[31]}}, z_reg};
            cfod_pkg::B_XM: op_b = xm_reg;
            cfod_pkg::B_XP: op_b = xp_reg;
            cfod_pkg::B_YP: op_b = yp_reg;
            cfod_pkg::B_YM: op_b = ym_reg;
            default:        op_b = '0;
        endcase
    end

    cfod_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .op_a  (op_a),
        .op_b  (op_b),
        .sums  (sums)
    );

    // ---------------- bound checks ----------------
    // quotient < 0 exactly when n <= -d; quotient >= lim exactly when n >= lim*d
    assign chk_n   = sums[cnt_reg[2:0]];
    assign chk_neg = (chk_n + $signed({20'd0, den_reg})) <= 0;
    assign bigx    = colz_reg || (chk_n >= $signed({7'd0, limx_reg}));
    assign bigy    = rowz_reg || (chk_n >= $signed({7'd0, limy_reg}));

    always_ff @(posedge clk)
    begin
        if (q_acc)
        begin
            outside_reg <= 1'b0;
            dead_reg    <= 1'b0;
        end
        else if (state_reg == cfod_pkg::ST_CHECK)
        begin
            unique case (cnt_reg[2:0])
                cfod_pkg::SUM_NORM: dead_reg <= ign_reg && (chk_n <= cfod_pkg::NORM_LIMIT);
                cfod_pkg::SUM_PX:   outside_reg <= outside_reg | chk_neg | bigx;
                cfod_pkg::SUM_PY:   outside_reg <= outside_reg | chk_neg | bigy;
                cfod_pkg::SUM_LX:   outside_reg <= outside_reg | chk_neg;
                cfod_pkg::SUM_LY:   outside_reg <= outside_reg | bigy;
                cfod_pkg::SUM_UX:   outside_reg <= outside_reg | bigx;
                cfod_pkg::SUM_UY:   outside_reg <= outside_reg | chk_neg;
                default: ;
            endcase
        end
    end

    // ---------------- pixel index ----------------
    cfod_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (div_done && (state_reg == cfod_pkg::ST_DIVX))
        begin
            px_reg <= div_q;
        end
        if (div_done && (state_reg == cfod_pkg::ST_DIVY))
        begin
            py_reg <= div_q;
        end
    end

    // ---------------- depth image ----------------
    assign wcol_ext  = {4'd0, pixel_col};
    assign wrow_ext  = {4'd0, pixel_row};
    assign pcol_ext  = 13'(px_reg);
    assign prow_ext  = 13'(py_reg);
    assign mem_we    = in_acc
                       && ((req_type == cfod_pkg::REQ_DEPTH) || (req_type == cfod_pkg::REQ_EMPTY))
                       && (wcol_ext < 13'(MAX_COLS)) && (wrow_ext < 13'(MAX_ROWS));
    assign mem_waddr = {wrow_ext[RW-1:0], wcol_ext[CW-1:0]};
    assign mem_wdata = (req_type == cfod_pkg::REQ_EMPTY) ? {1'b1, 32'd0} : {1'b0, depth_value};
    assign mem_raddr = {prow_ext[RW-1:0], pcol_ext[CW-1:0]};

    cfod_depth_mem #(
        .AW (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // ---------------- sequencer ----------------
    assign fin_go = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cfod_pkg::ST_IDLE:  if (q_acc) state_next = cfod_pkg::ST_MAC;
            cfod_pkg::ST_MAC:
                if (cnt_reg == 5'(cfod_pkg::NUM_TERMS)) state_next = cfod_pkg::ST_CHECK;
            cfod_pkg::ST_CHECK:
                if (cnt_reg == 5'(cfod_pkg::NUM_SUMS - 1)) state_next = cfod_pkg::ST_DIVX;
            cfod_pkg::ST_DIVX:  if (div_done) state_next = cfod_pkg::ST_DIVY;
            cfod_pkg::ST_DIVY:  if (div_done) state_next = cfod_pkg::ST_READ;
            cfod_pkg::ST_READ:  state_next = cfod_pkg::ST_FIN;
            cfod_pkg::ST_FIN:   if (fin_go) state_next = cfod_pkg::ST_IDLE;
            default:            state_next = cfod_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        mac_ctl   = '0;
        div_start = 1'b0;
        div_num   = sums[cfod_pkg::SUM_PX];
        mem_re    = 1'b0;
        unique case (state_reg)
            cfod_pkg::ST_MAC:
            begin
                if (cnt_reg < 5'(cfod_pkg::NUM_TERMS))
                begin
                    mac_ctl.valid = 1'b1;
                    mac_ctl.last  = term.last;
                    mac_ctl.idx   = term.idx;
                end
            end
            cfod_pkg::ST_DIVX:
            begin
                div_start = (cnt_reg == '0);
            end
            cfod_pkg::ST_DIVY:
            begin
                div_start = (cnt_reg == '0);
                div_num   = sums[cfod_pkg::SUM_PY];
            end
            cfod_pkg::ST_READ:
            begin
                mem_re = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        priority if (behind_reg)       fov_next = cfod_pkg::FOV_BEHIND;
        else if (dead_reg)             fov_next = cfod_pkg::FOV_FREE;
        else if (horizon_reg)          fov_next = cfod_pkg::FOV_HORIZON;
        else if (nonpos_reg)           fov_next = cfod_pkg::FOV_OUTSIDE;
        else if (outside_reg)          fov_next = cfod_pkg::FOV_OUTSIDE;
        else if (!have_reg)            fov_next = cfod_pkg::FOV_FREE;
        else if (mem_rdata[32])        fov_next = cfod_pkg::FOV_FREE;
        else if (z_reg > $signed(mem_rdata[31:0])) fov_next = cfod_pkg::FOV_OCCLUDED;
        else                           fov_next = cfod_pkg::FOV_FREE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfod_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= (state_next != state_reg) ? 5'd0 : cnt_reg + 5'd1;
            if ((state_reg == cfod_pkg::ST_FIN) && fin_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == cfod_pkg::ST_FIN) && fin_go)
        begin
            fov_status_reg <= fov_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign fov_status = fov_status_reg;

`ifndef SYNTHESIS
    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        q_acc |=> state_reg == cfod_pkg::ST_MAC)
        else $error("query accepted but sequencer did not start");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == cfod_pkg::ST_FIN))
        else $error("result raised outside final step");

    a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == cfod_pkg::ST_FIN) && fin_go) |=> out_valid)
        else $error("finished query lost");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !mem_re)
        else $error("pixel write during query read");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fov_status <= 3'(cfod_pkg::FOV_OCCLUDED))
        else $error("bad status code");
`endif

endmodule

@@ verif/camera_fov_occlusion_test_tb.sv @@
// Testbench for the camera field-of-view and occlusion test block.
module camera_fov_occlusion_test_tb;

    typedef struct {
        cfod_pkg::req_t     kind;
        logic signed [31:0] pos_x, pos_y, pos_z;
        logic signed [31:0] box_x, box_y, box_z;
        logic               ign, have;
        logic [8:0]         col, row;
        logic signed [31:0] depth;
    } request_t;

    localparam longint PIX_SAT = 64'd1099511627776;
    localparam int STORE_SIZE = 512 * 512;
    localparam longint CYCLE_LIMIT = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] req_type = 2'd0;
    logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic signed [31:0] box_x = '0, box_y = '0, box_z = '0;
    logic skip_horizon = 1'b0, has_depth_map = 1'b0;
    logic [8:0] pixel_col = '0, pixel_row = '0;
    logic signed [31:0] depth_value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [2:0] fov_status;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    camera_fov_occlusion_test dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .box_x(box_x), .box_y(box_y), .box_z(box_z),
        .skip_horizon(skip_horizon), .has_depth_map(has_depth_map),
        .pixel_col(pixel_col), .pixel_row(pixel_row), .depth_value(depth_value),
        .out_valid(out_valid), .out_stall(out_stall), .fov_status(fov_status),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow configuration and depth image
    logic [30:0] fx_q = '0, fy_q = '0;
    logic signed [31:0] skew_q = '0, cx_q = '0, cy_q = '0;
    logic [9:0] cols_q = 10'd512, rows_q = 10'd512;
    logic signed [31:0] img_depth [STORE_SIZE];
    bit img_empty [STORE_SIZE];
    bit img_written [STORE_SIZE];

    request_t pending_reqs[$];
    cfod_pkg::fov_t expected_fov[$];
    int mismatches = 0;
    int accepted = 0;
    longint cycles = 0;

    function automatic logic signed [127:0] mag128(input logic signed [31:0] v);
        logic signed [127:0] w;
        w = v;
        return (w < 0) ? -w : w;
    endfunction

    function automatic longint pixel_index(input logic signed [127:0] num,
                                           input logic signed [127:0] den);
        logic signed [127:0] q;
        q = num / den;
        if (q > PIX_SAT) q = PIX_SAT;
        if (q < -PIX_SAT) q = -PIX_SAT;
        return longint'(q);
    endfunction

    function automatic cfod_pkg::fov_t classify(input request_t r, output bit reads,
                                                output int unsigned ix);
        logic signed [127:0] x, y, z, bx, by, bz, fx, fy, sk, cx, cy, d, nrm;
        longint px, py, lx, ly, ux, uy, cols, rows;
        reads = 0;
        ix = 0;
        x = r.pos_x; y = r.pos_y; z = r.pos_z;
        bx = mag128(r.box_x); by = mag128(r.box_y); bz = mag128(r.box_z);
        fx = fx_q; fy = fy_q; sk = skew_q; cx = cx_q; cy = cy_q;
        if (z - bz < -128'sd32768) return cfod_pkg::FOV_BEHIND;
        nrm = x * x + y * y + z * z;
        if (r.ign && nrm <= 128'sd2147483648) return cfod_pkg::FOV_FREE;
        if (!r.ign && z + bz > 128'sd655360) return cfod_pkg::FOV_HORIZON;
        if (z <= 0) return cfod_pkg::FOV_OUTSIDE;
        d = z <<< 16;
        px = pixel_index(fx * x + sk * y + cx * z, d);
        py = pixel_index(fy * y + cy * z, d);
        lx = pixel_index(fx * (x - bx) + sk * (y + by) + cx * z, d);
        ly = pixel_index(fy * (y + by) + cy * z, d);
        ux = pixel_index(fx * (x + bx) + sk * (y - by) + cx * z, d);
        uy = pixel_index(fy * (y - by) + cy * z, d);
        cols = (cols_q > 512) ? 512 : cols_q;
        rows = (rows_q > 512) ? 512 : rows_q;
        if ((lx < px ? lx : px) < 0 || (ux > px ? ux : px) > cols - 1)
            return cfod_pkg::FOV_OUTSIDE;
        if ((uy < py ? uy : py) < 0) return cfod_pkg::FOV_OUTSIDE;
        if ((ly > py ? ly : py) > rows - 1) return cfod_pkg::FOV_OUTSIDE;
        if (!r.have) return cfod_pkg::FOV_FREE;
        ix = int'(py) * 512 + int'(px);
        reads = 1;
        if (img_empty[ix]) return cfod_pkg::FOV_FREE;
        return (r.pos_z > img_depth[ix]) ? cfod_pkg::FOV_OCCLUDED : cfod_pkg::FOV_FREE;
    endfunction

    function automatic void store_pixel(input request_t r);
        int unsigned ix;
        ix = r.row * 512 + r.col;
        img_written[ix] = 1;
        if (r.kind == cfod_pkg::REQ_DEPTH)
        begin
            img_depth[ix] = r.depth;
            img_empty[ix] = 0;
        end
        else
            img_empty[ix] = 1;
    endfunction

    // Queue a request; a query that would read a never-written pixel gets a write first.
    task automatic push_request(input request_t r);
        bit reads;
        int unsigned ix;
        request_t w;
        cfod_pkg::fov_t st;
        if (r.kind == cfod_pkg::REQ_QUERY)
        begin
            st = classify(r, reads, ix);
            if (reads && !img_written[ix])
            begin
                w = r;
                w.kind = ($urandom_range(3) == 0) ? cfod_pkg::REQ_EMPTY : cfod_pkg::REQ_DEPTH;
                w.col = 9'(ix % 512);
                w.row = 9'(ix / 512);
                w.depth = r.pos_z + $signed($urandom_range(262144)) - 131072;
                store_pixel(w);
                pending_reqs.push_back(w);
                st = classify(r, reads, ix);
            end
            pending_reqs.push_back(r);
            expected_fov.push_back(st);
        end
        else
        begin
            if (r.kind != cfod_pkg::REQ_NONE) store_pixel(r);
            pending_reqs.push_back(r);
        end
    endtask

    task automatic write_reg(input cfod_pkg::reg_t idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            cfod_pkg::REG_FOCAL_X:  fx_q = val[30:0];
            cfod_pkg::REG_FOCAL_Y:  fy_q = val[30:0];
            cfod_pkg::REG_SKEW:     skew_q = val;
            cfod_pkg::REG_CENTER_X: cx_q = val;
            cfod_pkg::REG_CENTER_Y: cy_q = val;
            cfod_pkg::REG_COLS:     cols_q = val[9:0];
            cfod_pkg::REG_ROWS:     rows_q = val[9:0];
            default: ;
        endcase
    endtask

    task automatic set_camera(input logic [31:0] fx, fy, sk, cx, cy, cols, rows);
        write_reg(cfod_pkg::REG_FOCAL_X, fx);
        write_reg(cfod_pkg::REG_FOCAL_Y, fy);
        write_reg(cfod_pkg::REG_SKEW, sk);
        write_reg(cfod_pkg::REG_CENTER_X, cx);
        write_reg(cfod_pkg::REG_CENTER_Y, cy);
        write_reg(cfod_pkg::REG_COLS, cols);
        write_reg(cfod_pkg::REG_ROWS, rows);
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || expected_fov.size() != 0 || in_valid)
            @(posedge clk);
        repeat (64) @(posedge clk);
    endtask

    function automatic request_t blank_query();
        request_t r;
        r.kind = cfod_pkg::REQ_QUERY;
        r.pos_x = 0; r.pos_y = 0; r.pos_z = 32'sh10000;
        r.box_x = 0; r.box_y = 0; r.box_z = 0;
        r.ign = 0; r.have = 1; r.col = 0; r.row = 0; r.depth = 0;
        return r;
    endfunction

    function automatic request_t noise_request();
        request_t r;
        r.kind = cfod_pkg::req_t'($urandom_range(3));
        r.pos_x = $urandom; r.pos_y = $urandom; r.pos_z = $urandom;
        r.box_x = $urandom; r.box_y = $urandom; r.box_z = $urandom;
        r.ign = $urandom; r.have = $urandom;
        r.col = $urandom; r.row = $urandom; r.depth = $urandom;
        return r;
    endfunction

    // Query near the optical axis with a small box, at times behind or past the horizon.
    function automatic request_t sane_query();
        request_t r;
        longint z;
        r = blank_query();
        z = $urandom_range(32'h8000, 32'h98000);
        r.pos_z = z;
        r.pos_x = (longint'($urandom_range(2400)) - 1200) * z / 1000;
        r.pos_y = (longint'($urandom_range(2400)) - 1200) * z / 1000;
        r.box_x = $signed($urandom_range(16'h3000)) * ($urandom_range(1) ? 1 : -1);
        r.box_y = $signed($urandom_range(16'h3000)) * ($urandom_range(1) ? 1 : -1);
        r.box_z = $signed($urandom_range(16'h8000)) * ($urandom_range(1) ? 1 : -1);
        r.ign = ($urandom_range(3) == 0);
        r.have = ($urandom_range(7) != 0);
        if ($urandom_range(15) == 0) r.pos_z = -$signed($urandom_range(32'h20000));
        if ($urandom_range(15) == 0) r.pos_z = $urandom_range(32'ha0000, 32'hc0000);
        if ($urandom_range(31) == 0)
        begin
            r.pos_x = $signed($urandom_range(16'h8000)) - 16'sh4000;
            r.pos_y = $signed($urandom_range(16'h8000)) - 16'sh4000;
            r.pos_z = $urandom_range(16'h8000);
        end
        return r;
    endfunction

    task automatic random_phase(input int count);
        request_t r;
        repeat (count)
        begin
            if ($urandom_range(9) < 7)
                push_request(sane_query());
            else if ($urandom_range(1))
                push_request(noise_request());
            else
            begin
                r = noise_request();
                r.kind = $urandom_range(1) ? cfod_pkg::REQ_DEPTH : cfod_pkg::REQ_EMPTY;
                push_request(r);
                r = sane_query();
                r.have = 1;
                push_request(r);
            end
        end
        drain();
    endtask

    // driver
    int gap_left = 0;
    bit burst = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (in_valid) accepted <= accepted + 1;
            if ($urandom_range(63) == 0) burst <= ~burst;
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                automatic request_t r = pending_reqs.pop_front();
                req_type <= r.kind;
                pos_x <= r.pos_x; pos_y <= r.pos_y; pos_z <= r.pos_z;
                box_x <= r.box_x; box_y <= r.box_y; box_z <= r.box_z;
                skip_horizon <= r.ign; has_depth_map <= r.have;
                pixel_col <= r.col; pixel_row <= r.row; depth_value <= r.depth;
                in_valid <= 1'b1;
                if (burst)
                    gap_left <= 0;
                else if ($urandom_range(99) < 60)
                    gap_left <= 0;
                else if ($urandom_range(99) < 85)
                    gap_left <= $urandom_range(1, 3);
                else
                    gap_left <= $urandom_range(10, 40);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall, with one long hold to back the block up
    int hold_left = 0;
    bit held_once = 0;
    always @(posedge clk)
    begin
        if (!held_once && accepted >= 300)
        begin
            held_once <= 1;
            hold_left <= 600;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (burst)
            out_stall <= 1'b0;
        else if ($urandom_range(299) == 0)
        begin
            hold_left <= $urandom_range(10, 40);
            out_stall <= 1'b1;
        end
        else if ($urandom_range(99) < 80)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(9) != 0);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_fov.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result fov_status=%0d", fov_status);
            end
            else
            begin
                automatic cfod_pkg::fov_t want = expected_fov.pop_front();
                if (fov_status !== want)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("fov_status mismatch: expected %0d, got %0d",
                                 want, fov_status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("camera_fov_occlusion_test_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        request_t r;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset camera: everything projects to pixel zero
        push_request(blank_query());
        random_phase(30);

        set_camera(32'd256 << 16, 32'd256 << 16, 32'd0, 32'd256 << 16, 32'd256 << 16,
                   32'd512, 32'd512);
        // directed corners
        r = blank_query(); r.kind = cfod_pkg::REQ_DEPTH; r.col = 9'd511; r.row = 9'd511;
        r.depth = 32'sh7fffffff; push_request(r);
        r.kind = cfod_pkg::REQ_EMPTY; r.col = 0; r.row = 0; push_request(r);
        r.kind = cfod_pkg::REQ_NONE; push_request(r);
        r = blank_query(); r.pos_z = -32'sh8001; push_request(r);
        r.pos_z = -32'sh8000; push_request(r);
        r.box_z = 32'sh80000000; push_request(r);
        r = blank_query(); r.ign = 1; r.pos_z = 0; r.pos_x = 32'sh8000;
        push_request(r);
        r.pos_x = 32'sh10000; push_request(r);
        r = blank_query(); r.pos_z = 32'sha0000; push_request(r);
        r.pos_z = 32'sha0001; push_request(r);
        r.ign = 1; push_request(r);
        r = blank_query(); r.pos_z = 0; push_request(r);
        r.pos_z = 32'sh7fffffff; r.ign = 1; push_request(r);
        r = blank_query(); r.pos_x = 32'sh7fffffff; r.pos_y = 32'sh80000000;
        r.ign = 1; push_request(r);
        r = blank_query(); r.box_x = 32'sh80000000; r.box_y = 32'sh7fffffff;
        push_request(r);
        r = blank_query(); r.have = 0; push_request(r);
        r = blank_query(); r.pos_x = 32'shff00; r.pos_y = 32'shff00; push_request(r);
        random_phase(210);

        set_camera(32'd40 << 16, 32'd30 << 16, 32'hfffc0000, 32'd32 << 16, 32'd24 << 16,
                   32'd64, 32'd48);
        random_phase(130);

        // extremes, including zero and oversize columns and rows
        set_camera(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                   32'd0, 32'd1023);
        random_phase(45);
        set_camera(32'd0, 32'd1, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                   32'd1023, 32'd0);
        random_phase(45);
        set_camera(32'd1 << 16, 32'd1 << 16, 32'd0, 32'd0, 32'd0, 32'd1, 32'd1);
        random_phase(55);

        set_camera($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        random_phase(45);
        set_camera({$urandom_range(511), 16'h0}, {$urandom_range(511), 16'h0},
                   $urandom_range(32'h40000) - 32'h20000,
                   {$urandom_range(511), 16'h0}, {$urandom_range(511), 16'h0},
                   $urandom_range(1, 512), $urandom_range(1, 512));
        random_phase(185);

        repeat (100) @(posedge clk);
        if (mismatches == 0 && expected_fov.size() == 0)
            $display("camera_fov_occlusion_test_tb: PASS");
        else
            $display("camera_fov_occlusion_test_tb: FAIL");
        $finish;
    end

endmodule

@@ camera_fov_occlusion_test.f @@
hw/rtl/cfod_pkg.sv
hw/rtl/cfod_mac.sv
hw/rtl/cfod_div.sv
hw/rtl/cfod_depth_mem.sv
hw/rtl/camera_fov_occlusion_test.sv
verif/camera_fov_occlusion_test_tb.sv
